// ----- sv/srtt_pkg.sv -----
// shared types and constants for the route travel time sampler
// no dependencies
package srtt_pkg;

  localparam int unsigned ClkW = 28;
  localparam int unsigned RemW = 28;
  localparam int unsigned TotW = 32;
  localparam int unsigned SpanW = 25;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned DivNumW = 36;
  localparam int unsigned DivDenW = 25;
  localparam int unsigned DivCntW = 6;

  localparam logic [19:0] WeekSec = 20'd604800;
  localparam logic [ClkW-1:0] WeekQ8 = 28'd154828800;
  localparam logic [TotW-1:0] TotMax = 32'hFFFF_FFFF;

  localparam logic CfgInterval = 1'b0;
  localparam logic CfgSegments = 1'b1;

  typedef enum logic [1:0] {
    REQ_WR_SPEED  = 2'd0,
    REQ_WR_LENGTH = 2'd1,
    REQ_START     = 2'd2,
    REQ_DRAW      = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SKIP,
    S_DIVK,
    S_ADDR,
    S_READ,
    S_LAUNCH,
    S_DIVT,
    S_MUL,
    S_SUB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               go;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
    logic [DivDenW-1:0] rem;
  } div_rsp_t;

  function automatic logic [TotW-1:0] sat_add(input logic [TotW-1:0] a,
                                              input logic [DivNumW-1:0] b);
    logic [DivNumW:0] s;
    s = (DivNumW+1)'(a) + (DivNumW+1)'(b);
    return (s > (DivNumW+1)'(TotMax)) ? TotMax : s[TotW-1:0];
  endfunction

endpackage

// ----- sv/srtt_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on srtt_pkg
module srtt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srtt_pkg::div_req_t req_i,
  output srtt_pkg::div_rsp_t rsp_o
);

  logic [srtt_pkg::DivNumW-1:0] quot_q, quot_d;
  logic [srtt_pkg::DivDenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [srtt_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic run_q, run_d, done_q, done_d;
  logic [srtt_pkg::DivDenW:0] trial;
  logic fits;

  assign trial = {rem_q, quot_q[srtt_pkg::DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.go) begin
      quot_d = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = fits ? srtt_pkg::DivDenW'(trial - {1'b0, den_q})
                    : srtt_pkg::DivDenW'(trial);
      quot_d = {quot_q[srtt_pkg::DivNumW-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == srtt_pkg::DivCntW'(srtt_pkg::DivNumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- sv/srtt_speed_mem.sv -----
// speed table memory, one write and one registered read port
// depends on srtt_pkg
module srtt_speed_mem #(
  parameter int unsigned Depth = 537600,
  parameter int unsigned AddrW = 20
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [srtt_pkg::SpeedW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [srtt_pkg::SpeedW-1:0] rdata_o
);

  logic [srtt_pkg::SpeedW-1:0] mem_q [Depth];
  logic [srtt_pkg::SpeedW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/stochastic_route_travel_time_top.sv -----
// route travel time sampler: sequencer, state registers and segment lengths
// depends on srtt_pkg, srtt_div, srtt_speed_mem
//
// channel   | handshake                  | payload
// request   | start_i / busy_o           | req_type_i .. draw_bucket_i
// result    | done_o (one-cycle strobe)  | travel_time_o, saturated_o
// config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// a draw sub-step makes two passes of the shared 36-bit divider at one bit a cycle
// (interval number, then time to finish the segment). start and segment ends skip
// empty segments one at a time. reset clears control state only; tables stay
// undefined until written. results cannot be stalled.
module stochastic_route_travel_time_top #(
  parameter int unsigned MAX_SEGMENTS   = 8,
  parameter int unsigned BUCKETS        = 100,
  parameter int unsigned WEEK_INTERVALS = 672
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  segment_sel_i,
  input  logic [16:0] table_index_i,
  input  logic [15:0] speed_value_i,
  input  logic [19:0] length_value_i,
  input  logic [19:0] start_seconds_i,
  input  logic [6:0]  draw_bucket_i,
  output logic        done_o,
  output logic [31:0] travel_time_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned PerSeg = WEEK_INTERVALS * BUCKETS;
  localparam int unsigned Depth  = MAX_SEGMENTS * PerSeg;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned SegW   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SelW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned BkW    = $clog2(BUCKETS);
  localparam int unsigned KW     = $clog2(WEEK_INTERVALS);

  srtt_pkg::state_e state_q, state_d;
  srtt_pkg::req_e   req;

  logic [16:0] interval_q;
  logic [3:0]  seguse_q;
  logic [19:0] lengths_q [MAX_SEGMENTS];

  logic [SegW-1:0] active_q, active_d, seg_n;
  logic [srtt_pkg::RemW-1:0] rem_q, rem_d;
  logic [srtt_pkg::ClkW-1:0] clock_q, clock_d, bound_q, bound_d;
  logic [srtt_pkg::TotW-1:0] total_q, total_d;
  logic running_q, running_d;
  logic [BkW-1:0] bucket_q, bucket_d;
  logic [KW-1:0] kidx_q, kidx_d;
  logic [AW-1:0] addr_q, addr_d, wr_addr;
  logic [srtt_pkg::SpeedW-1:0] speed_q, speed_d, rd_speed;
  logic [srtt_pkg::SpanW-1:0] dt_q, dt_d, span;
  logic [40:0] prod_q, prod_d;

  logic accept, wr_speed, last_gone, fits;
  logic [19:0] cur_len, start_s;
  logic [srtt_pkg::ClkW:0] bnd_raw;
  logic [srtt_pkg::DivNumW:0] fin_clock;
  srtt_pkg::div_req_t div_req;
  srtt_pkg::div_rsp_t div_rsp;

  assign req       = srtt_pkg::req_e'(req_type_i);
  assign accept    = start_i && (state_q == srtt_pkg::S_IDLE);
  assign busy_o    = (state_q != srtt_pkg::S_IDLE);
  assign seg_n     = (seguse_q > MAX_SEGMENTS) ? SegW'(MAX_SEGMENTS) : SegW'(seguse_q);
  assign last_gone = (active_q >= seg_n);
  assign cur_len   = lengths_q[active_q[SelW-1:0]];
  assign span      = {((interval_q == '0) ? 17'd1 : interval_q), 8'd0};
  assign start_s   = (start_seconds_i >= srtt_pkg::WeekSec) ?
                     (start_seconds_i - srtt_pkg::WeekSec) : start_seconds_i;
  assign bnd_raw   = (srtt_pkg::ClkW+1)'(clock_q) - (srtt_pkg::ClkW+1)'(div_rsp.rem)
                   + (srtt_pkg::ClkW+1)'(span);
  assign fin_clock = (srtt_pkg::DivNumW+1)'(clock_q) + (srtt_pkg::DivNumW+1)'(div_rsp.quot);
  assign fits      = fin_clock <= (srtt_pkg::DivNumW+1)'(bound_q);

  assign wr_speed = accept && (req == srtt_pkg::REQ_WR_SPEED)
                 && (32'(segment_sel_i) < MAX_SEGMENTS) && (32'(table_index_i) < PerSeg);
  assign wr_addr  = AW'(32'(segment_sel_i) * PerSeg + 32'(table_index_i));

  srtt_speed_mem #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_speed),
    .waddr_i (wr_addr),
    .wdata_i (speed_value_i),
    .re_i    (state_q == srtt_pkg::S_READ),
    .raddr_i (addr_q),
    .rdata_o (rd_speed)
  );

  srtt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srtt_pkg::S_IDLE: begin
        if (accept) begin
          if (req == srtt_pkg::REQ_START) begin
            state_d = srtt_pkg::S_SKIP;
          end else if (req == srtt_pkg::REQ_DRAW && running_q) begin
            state_d = last_gone ? srtt_pkg::S_DONE : srtt_pkg::S_DIVK;
          end
        end
      end
      srtt_pkg::S_SKIP: begin
        if (last_gone) begin
          state_d = srtt_pkg::S_DONE;
        end else if (cur_len != '0) begin
          state_d = srtt_pkg::S_IDLE;
        end
      end
      srtt_pkg::S_DIVK:   if (div_rsp.done) state_d = srtt_pkg::S_ADDR;
      srtt_pkg::S_ADDR:   state_d = srtt_pkg::S_READ;
      srtt_pkg::S_READ:   state_d = srtt_pkg::S_LAUNCH;
      srtt_pkg::S_LAUNCH: state_d = srtt_pkg::S_DIVT;
      srtt_pkg::S_DIVT: begin
        if (div_rsp.done) state_d = fits ? srtt_pkg::S_SKIP : srtt_pkg::S_MUL;
      end
      srtt_pkg::S_MUL:    state_d = srtt_pkg::S_SUB;
      srtt_pkg::S_SUB:    state_d = srtt_pkg::S_IDLE;
      srtt_pkg::S_DONE:   state_d = srtt_pkg::S_IDLE;
      default:            state_d = srtt_pkg::S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    active_d  = active_q;
    rem_d     = rem_q;
    clock_d   = clock_q;
    bound_d   = bound_q;
    total_d   = total_q;
    running_d = running_q;
    bucket_d  = bucket_q;
    kidx_d    = kidx_q;
    addr_d    = addr_q;
    speed_d   = speed_q;
    dt_d      = dt_q;
    prod_d    = prod_q;
    div_req   = '0;
    case (state_q)
      srtt_pkg::S_IDLE: begin
        if (accept && req == srtt_pkg::REQ_START) begin
          clock_d   = {start_s, 8'd0};
          total_d   = '0;
          active_d  = '0;
          rem_d     = '0;
          running_d = 1'b1;
        end else if (accept && req == srtt_pkg::REQ_DRAW && running_q && !last_gone) begin
          bucket_d = (32'(draw_bucket_i) >= BUCKETS) ? BkW'(BUCKETS - 1)
                                                     : BkW'(draw_bucket_i);
          div_req.go       = 1'b1;
          div_req.dividend = srtt_pkg::DivNumW'(clock_q);
          div_req.divisor  = span;
        end
      end
      srtt_pkg::S_SKIP: begin
        if (!last_gone) begin
          if (cur_len == '0) begin
            active_d = active_q + 1'b1;
          end else begin
            rem_d = {cur_len, 8'd0};
          end
        end
      end
      srtt_pkg::S_DIVK: begin
        if (div_rsp.done) begin
          kidx_d  = (div_rsp.quot >= srtt_pkg::DivNumW'(WEEK_INTERVALS))
                  ? KW'(WEEK_INTERVALS - 1) : KW'(div_rsp.quot);
          bound_d = (bnd_raw > (srtt_pkg::ClkW+1)'(srtt_pkg::WeekQ8))
                  ? srtt_pkg::WeekQ8 : bnd_raw[srtt_pkg::ClkW-1:0];
        end
      end
      srtt_pkg::S_ADDR: begin
        addr_d = AW'(32'(active_q) * PerSeg + 32'(kidx_q) * BUCKETS + 32'(bucket_q));
      end
      srtt_pkg::S_LAUNCH: begin
        // a zero speed counts as the smallest step
        speed_d          = (rd_speed == '0) ? srtt_pkg::SpeedW'(1) : rd_speed;
        div_req.go       = 1'b1;
        div_req.dividend = {rem_q, 8'd0};
        div_req.divisor  = srtt_pkg::DivDenW'((rd_speed == '0) ? srtt_pkg::SpeedW'(1)
                                                               : rd_speed);
      end
      srtt_pkg::S_DIVT: begin
        if (div_rsp.done) begin
          if (fits) begin
            total_d  = srtt_pkg::sat_add(total_q, div_rsp.quot);
            clock_d  = (fin_clock >= (srtt_pkg::DivNumW+1)'(srtt_pkg::WeekQ8))
                     ? '0 : fin_clock[srtt_pkg::ClkW-1:0];
            active_d = active_q + 1'b1;
          end else begin
            dt_d = srtt_pkg::SpanW'(bound_q - clock_q);
          end
        end
      end
      srtt_pkg::S_MUL: begin
        prod_d = 41'(speed_q) * 41'(dt_q);
      end
      srtt_pkg::S_SUB: begin
        rem_d   = rem_q - prod_q[srtt_pkg::RemW+7:8];
        clock_d = (bound_q >= srtt_pkg::WeekQ8) ? '0 : bound_q;
        total_d = srtt_pkg::sat_add(total_q, srtt_pkg::DivNumW'(dt_q));
      end
      srtt_pkg::S_DONE: begin
        running_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= srtt_pkg::S_IDLE;
      active_q   <= '0;
      rem_q      <= '0;
      clock_q    <= '0;
      total_q    <= '0;
      running_q  <= 1'b0;
      interval_q <= 17'd900;
      seguse_q   <= 4'd8;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      rem_q     <= rem_d;
      clock_q   <= clock_d;
      total_q   <= total_d;
      running_q <= running_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          srtt_pkg::CfgInterval: interval_q <= cfg_data_i[16:0];
          srtt_pkg::CfgSegments: seguse_q   <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q  <= bound_d;
    bucket_q <= bucket_d;
    kidx_q   <= kidx_d;
    addr_q   <= addr_d;
    speed_q  <= speed_d;
    dt_q     <= dt_d;
    prod_q   <= prod_d;
    if (accept && req == srtt_pkg::REQ_WR_LENGTH && 32'(segment_sel_i) < MAX_SEGMENTS) begin
      lengths_q[SelW'(segment_sel_i)] <= length_value_i;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign done_o        = (state_q == srtt_pkg::S_DONE);
  assign travel_time_o = total_q;
  assign saturated_o   = (total_q == srtt_pkg::TotMax);

`ifndef SYNTH
  a_clock_in_week: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_q < srtt_pkg::WeekQ8)
    else $error("clock of week past week end");

  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srtt_pkg::S_SUB) |=> (rem_q <= $past(rem_q)))
    else $error("remaining length grew on a boundary step");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && !running_q))
    else $error("sample still running after its result beat");

  a_idle_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req == srtt_pkg::REQ_DRAW && !running_q) |=> !busy_o)
    else $error("draw while idle started work");
`endif

endmodule
